### rtl/csr_sparse_matvec_accumulator_top_assert.svh
// assertion macros for the sparse matrix-vector accumulator
`ifndef CSR_SPARSE_MATVEC_ACCUMULATOR_TOP_ASSERT_SVH
`define CSR_SPARSE_MATVEC_ACCUMULATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define CSMV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csmv assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define CSMV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csmv assertion failed");
`else
`define CSMV_ASSERT_NOW(label, ante, cons)
`define CSMV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/csmv_pkg.sv
// shared types, constants and helpers of the sparse matrix-vector accumulator
package csmv_pkg;

  localparam int VECTOR_DEPTH = 4096;
  localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  localparam int ROW_W        = 20;
  localparam int ROWCNT_W     = 21;
  localparam logic [ROWCNT_W-1:0] ROW_LIMIT = 21'd1048576;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_NZ    = 2'd1,
    FUNC_CLOSE = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        index;
    logic signed [31:0] value;
    logic               last_in_row;
  } csmv_in_t;

  typedef struct packed {
    logic signed [63:0] row_sum;
    logic [ROW_W-1:0]   row_number;
    logic               last_row;
  } csmv_out_t;

  // item handed from the accept stage to the mac pipeline
  typedef struct packed {
    logic               valid;
    logic [1:0]         func;
    logic signed [31:0] value;
    logic               last_in_row;
    logic               in_range;
  } csmv_issue_t;

  // pipeline occupancy, used for the result queue credit
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } csmv_mac_stat_t;

  typedef struct packed {
    logic      valid;
    csmv_out_t data;
  } csmv_push_t;

  // index of the final row for a programmed row count
  function automatic logic [ROW_W-1:0] last_row_idx(logic [ROWCNT_W-1:0] rc);
    logic [ROWCNT_W-1:0] m1;
    m1 = rc - 21'd1;
    if (rc == '0) begin
      return '0;
    end else if (rc > ROW_LIMIT) begin
      return {ROW_W{1'b1}};
    end else begin
      return m1[ROW_W-1:0];
    end
  endfunction

endpackage

### rtl/csmv_ram.sv
// generic single-write, single-read ram with registered read data
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/csmv_mac.sv
// multiply stage and saturating row accumulator with row counter
module csmv_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csmv_pkg::csmv_issue_t       issue,
  input  logic signed [31:0]          vec_rdata,
  input  logic [csmv_pkg::ROW_W-1:0]  last_idx,
  output csmv_pkg::csmv_push_t        push,
  output csmv_pkg::csmv_mac_stat_t    stat
);
  import csmv_pkg::*;

  // stage 1: item with vector entry arriving from the ram
  logic               s1_valid_r;
  logic [1:0]         s1_func_r;
  logic signed [31:0] s1_value_r;
  logic               s1_last_r;
  logic               s1_inr_r;

  // stage 2: registered product
  logic               s2_valid_r;
  logic [1:0]         s2_func_r;
  logic               s2_last_r;
  logic signed [63:0] prod_r;

  logic signed [63:0] sum_r, sum_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic signed [31:0] vec_op;
  logic signed [63:0] addend, raw_sum, sat_sum, acc;
  logic               emit;
  logic               final_row;

  assign vec_op = s1_inr_r ? vec_rdata : 32'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_func_r  <= issue.func;
    s1_value_r <= issue.value;
    s1_last_r  <= issue.last_in_row;
    s1_inr_r   <= issue.in_range;
    s2_func_r  <= s1_func_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= s1_value_r * vec_op;
  end

  // q32.32 product to q48.16, floor
  assign addend  = prod_r >>> 16;
  assign raw_sum = sum_r + addend;

  always_comb begin
    sat_sum = raw_sum;
    if (!sum_r[63] && !addend[63] && raw_sum[63]) begin
      sat_sum = {1'b0, {63{1'b1}}};
    end else if (sum_r[63] && addend[63] && !raw_sum[63]) begin
      sat_sum = {1'b1, 63'd0};
    end
  end

  always_comb begin
    case (s2_func_r)
      FUNC_NZ: begin
        acc  = sat_sum;
        emit = s2_last_r;
      end
      FUNC_CLOSE: begin
        acc  = sum_r;
        emit = 1'b1;
      end
      default: begin
        acc  = sum_r;
        emit = 1'b0;
      end
    endcase
  end

  assign final_row = (row_r == last_idx);

  always_comb begin
    sum_nxt = sum_r;
    row_nxt = row_r;
    if (s2_valid_r) begin
      if (emit) begin
        sum_nxt = '0;
        row_nxt = final_row ? '0 : row_r + 1'b1;
      end else begin
        sum_nxt = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      row_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      row_r <= row_nxt;
    end
  end

  assign push.valid           = s2_valid_r && emit;
  assign push.data.row_sum    = acc;
  assign push.data.row_number = row_r;
  assign push.data.last_row   = final_row;

  assign stat.s1_valid = s1_valid_r;
  assign stat.s2_valid = s2_valid_r;

endmodule

### rtl/csmv_ofifo.sv
// small result queue between the accumulator and the result channel
module csmv_ofifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csmv_pkg::csmv_push_t          push,
  input  logic                          pop,
  output logic                          not_empty,
  output csmv_pkg::csmv_out_t           head,
  output logic [csmv_pkg::FIFO_CW-1:0]  count
);
  import csmv_pkg::*;

  csmv_out_t          entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

### rtl/csr_sparse_matvec_accumulator_top.sv
// top level of the sparse matrix-vector accumulator
// usage:
//   load the dense vector first with func load transactions (index = position),
//   then stream nonzeros in csr order; a nonzero with last_in_row, or an
//   empty-row transaction, closes the row and sends one result transaction
//   with the saturated q48.16 sum, the row number and a final-row flag.
//   cfg_we/cfg_wdata set the row count; write it only while nothing is in flight.
// timing:
//   one input transaction per cycle while in_stall is low; a result shows on
//   out_valid once its closing transaction has passed the ram read at the
//   accepting edge, the multiply, then the accumulate into the queue.
//   the accumulator register is read and rewritten every cycle,
//   so back-to-back nonzeros of one row chain without bubbles.
// reset:
//   clears the row sum and row counter and sets the row count to one.
//   the vector memory is not cleared; entries must be loaded before use.
// stall:
//   results wait in a four-entry queue; in_stall rises when queued plus
//   in-flight transactions reach four, so nothing is lost while out_stall holds.
`include "csr_sparse_matvec_accumulator_top_assert.svh"

module csr_sparse_matvec_accumulator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  csmv_pkg::csmv_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output csmv_pkg::csmv_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [csmv_pkg::ROWCNT_W-1:0]   cfg_wdata
);
  import csmv_pkg::*;

  logic               in_accept;
  logic               in_range;
  logic [VEC_AW-1:0]  vec_addr;
  logic [31:0]        vec_rdata;
  logic               out_pop;
  logic [ROW_W-1:0]   last_idx_r;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [FIFO_CW:0]   outstanding;

  csmv_issue_t    issue;
  csmv_push_t     push;
  csmv_mac_stat_t mac_stat;

  // configuration kept as the index of the final row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r <= '0;
    end else if (cfg_we) begin
      last_idx_r <= last_row_idx(cfg_wdata);
    end
  end

  assign outstanding = (FIFO_CW + 1)'(fifo_cnt) + (FIFO_CW + 1)'(mac_stat.s1_valid)
                     + (FIFO_CW + 1)'(mac_stat.s2_valid);
  assign in_stall    = (outstanding >= (FIFO_CW + 1)'(FIFO_DEPTH));
  assign in_accept   = in_valid && !in_stall;

  assign in_range = (32'(in_data.index) < 32'(VECTOR_DEPTH));
  assign vec_addr = VEC_AW'(in_data.index);

  csmv_ram #(
    .WIDTH (32),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (in_accept && (in_data.func == FUNC_LOAD) && in_range),
    .waddr (vec_addr),
    .wdata (in_data.value),
    .re    (in_accept && (in_data.func == FUNC_NZ)),
    .raddr (vec_addr),
    .rdata (vec_rdata)
  );

  assign issue.valid       = in_accept;
  assign issue.func        = in_data.func;
  assign issue.value       = in_data.value;
  assign issue.last_in_row = in_data.last_in_row;
  assign issue.in_range    = in_range;

  csmv_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .vec_rdata (vec_rdata),
    .last_idx  (last_idx_r),
    .push      (push),
    .stat      (mac_stat)
  );

  assign out_pop = out_valid && !out_stall;

  csmv_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_pop),
    .not_empty (out_valid),
    .head      (out_data),
    .count     (fifo_cnt)
  );

  // a result never lands in a full queue
  `CSMV_ASSERT_NOW(a_queue_room, push.valid, (fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || out_pop)
  // an accepted transaction enters the mac pipeline on the next edge
  `CSMV_ASSERT_NEXT(a_pipe_fill, in_accept, mac_stat.s1_valid)
  // the final-row flag only rides on the programmed last row
  `CSMV_ASSERT_NOW(a_last_row_idx, out_valid && out_data.last_row,
                   out_data.row_number == last_idx_r)

endmodule

### dv/csmv_row_sum_checker.sv
// row sum predictor and result comparison for the sparse matrix-vector accumulator
module csmv_row_sum_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  csmv_pkg::csmv_in_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  csmv_pkg::csmv_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [csmv_pkg::ROWCNT_W-1:0] cfg_wdata,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import csmv_pkg::*;

  localparam longint SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'h8000_0000_0000_0000;

  logic signed [31:0]  vec_mem [VECTOR_DEPTH];
  longint              row_acc;
  logic [ROW_W-1:0]    row_idx;
  logic [ROWCNT_W-1:0] rows_cfg;
  csmv_out_t           row_sum_q [$];
  int                  err_count = 0;

  assign errors = err_count;

  function automatic longint sat_accumulate(longint acc, longint addend);
    longint s;
    s = acc + addend;
    if (!acc[63] && !addend[63] && s[63]) return SUM_MAX;
    if (acc[63] && addend[63] && !s[63]) return SUM_MIN;
    return s;
  endfunction

  task automatic report(string what, longint got, longint want);
    err_count++;
    $display("csmv_row_sum_checker: %s mismatch, got %0h expected %0h at %0t",
             what, got, want, $realtime);
  endtask

  task automatic close_row();
    logic [ROWCNT_W-1:0] eff;
    logic                final_row;
    csmv_out_t           r;
    eff = rows_cfg;
    // zero counts as one row, anything above the limit clamps
    if (eff == '0) begin
      eff = 21'd1;
    end else if (eff > ROW_LIMIT) begin
      eff = ROW_LIMIT;
    end
    final_row = ({1'b0, row_idx} == eff - 1'b1);
    r.row_sum = row_acc;
    r.row_number = row_idx;
    r.last_row = final_row;
    row_sum_q.push_back(r);
    row_acc = 0;
    row_idx = final_row ? '0 : row_idx + 1'b1;
  endtask

  task automatic apply_matvec_item(csmv_in_t it);
    longint prod;
    case (it.func)
      FUNC_LOAD: vec_mem[it.index] = it.value;
      FUNC_NZ: begin
        prod = longint'($signed(it.value)) * longint'($signed(vec_mem[it.index]));
        // q32.32 to q48.16, floor
        row_acc = sat_accumulate(row_acc, prod >>> 16);
        if (it.last_in_row) close_row();
      end
      FUNC_CLOSE: close_row();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    csmv_out_t want;
    if (!rst_n) begin
      row_acc = 0;
      row_idx = '0;
      rows_cfg = 21'd1;
      row_sum_q.delete();
    end else begin
      if (cfg_we) rows_cfg = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (row_sum_q.size() == 0) begin
          report("unexpected result", out_data.row_sum, 0);
        end else begin
          want = row_sum_q.pop_front();
          if (out_data.row_sum !== want.row_sum)
            report("row_sum", out_data.row_sum, want.row_sum);
          if (out_data.row_number !== want.row_number)
            report("row_number", out_data.row_number, want.row_number);
          if (out_data.last_row !== want.last_row)
            report("last_row", out_data.last_row, want.last_row);
        end
      end
      if (in_valid && !in_stall) apply_matvec_item(in_data);
    end
    pending <= row_sum_q.size();
  end

endmodule

### dv/tb_top.sv
// testbench top for the sparse matrix-vector accumulator: stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csmv_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  csmv_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  csmv_out_t           out_data;
  logic                cfg_we;
  logic [ROWCNT_W-1:0] cfg_wdata;
  int                  errors;
  int                  pending;

  bit          idle_en;
  bit          hold_req;
  bit          hold_done;
  bit          loaded [VECTOR_DEPTH];
  logic [11:0] loaded_cols [$];

  csr_sparse_matvec_accumulator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  csmv_row_sum_checker row_sum_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #60000000;
    $display("tb_top: done, errors");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drive_item(logic [1:0] f, logic [11:0] idx, logic [31:0] val, logic last);
    csmv_in_t it;
    it.func = f;
    it.index = idx;
    it.value = val;
    it.last_in_row = last;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_entry(logic [11:0] idx, logic [31:0] val);
    drive_item(FUNC_LOAD, idx, val, 1'($urandom_range(0, 1)));
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return 32'($urandom_range(0, 262143)) - 32'd131072;
      default: return $urandom();
    endcase
  endfunction

  // nonzeros only address entries that have been loaded
  function automatic logic [11:0] rand_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  task automatic send_row(int nnz);
    if (nnz == 0) begin
      drive_item(FUNC_CLOSE, 12'($urandom), rand_value(), 1'($urandom_range(0, 1)));
    end else begin
      for (int k = 0; k < nnz; k++) begin
        drive_item(FUNC_NZ, rand_col(), rand_value(), k == nnz - 1);
      end
    end
  endtask

  task automatic random_phase(int n);
    int done_items;
    int nnz;
    done_items = 0;
    while (done_items < n) begin
      case ($urandom_range(0, 9))
        0: begin
          load_entry(12'($urandom), rand_value());
          done_items++;
        end
        1: begin
          case ($urandom_range(0, 2))
            0: drive_item(FUNC_UNUSED, 12'($urandom), $urandom(), 1'($urandom_range(0, 1)));
            1: begin
              drive_item(FUNC_CLOSE, 12'($urandom), $urandom(), 1'($urandom_range(0, 1)));
              done_items++;
            end
            default: begin
              // unterminated nonzeros, merged into whatever row comes next
              nnz = $urandom_range(1, 3);
              repeat (nnz) drive_item(FUNC_NZ, rand_col(), rand_value(), 1'b0);
              done_items += nnz;
            end
          endcase
        end
        default: begin
          nnz = $urandom_range(0, 6);
          send_row(nnz);
          done_items += (nnz == 0) ? 1 : nnz;
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_rows(logic [ROWCNT_W-1:0] rc);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= rc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, row count still at its reset value of one
    load_entry(12'd0, 32'h7FFF_FFFF);
    load_entry(12'd4095, 32'h8000_0000);
    load_entry(12'd1, 32'h0001_0000);
    load_entry(12'd2048, 32'hFFFF_0000);
    load_entry(12'd5, 32'hFFFF_FFFF);
    drive_item(FUNC_NZ, 12'd0, 32'h7FFF_FFFF, 1'b0);
    drive_item(FUNC_NZ, 12'd4095, 32'h8000_0000, 1'b1);
    // empty row with last flag set
    drive_item(FUNC_CLOSE, 12'd0, 32'h0000_0000, 1'b1);
    // tiny negative product rounds down to minus one lsb
    drive_item(FUNC_NZ, 12'd5, 32'h0000_0001, 1'b1);
    drive_item(FUNC_NZ, 12'd1, 32'h8000_0000, 1'b0);
    drive_item(FUNC_NZ, 12'd2048, 32'h7FFF_FFFF, 1'b1);
    drive_item(FUNC_UNUSED, 12'd4095, 32'hFFFF_FFFF, 1'b1);
    // pending sum closed by an empty-row transaction
    drive_item(FUNC_NZ, 12'd1, 32'h0001_0000, 1'b0);
    drive_item(FUNC_CLOSE, 12'd4095, 32'h7FFF_FFFF, 1'b0);
    drive_item(FUNC_NZ, 12'd4095, 32'h0000_0000, 1'b1);

    set_rows(21'd3);
    hold_req = 1'b1;
    random_phase(400);
    set_rows(21'd0);
    random_phase(200);
    set_rows(21'h1F_FFFF);
    random_phase(150);
    set_rows(ROW_LIMIT);
    random_phase(150);
    set_rows(21'($urandom_range(1, 12)));
    random_phase(250);

    // last part runs without idling on either side
    idle_en = 1'b0;
    set_rows(21'd5);
    random_phase(300);

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/csmv_pkg.sv
rtl/csmv_ram.sv
rtl/csmv_mac.sv
rtl/csmv_ofifo.sv
rtl/csr_sparse_matvec_accumulator_top.sv
dv/csmv_row_sum_checker.sv
dv/tb_top.sv
